// File: hdl/imusd_pkg.sv
// Shared types and constants for the IMU serial frame deframer.
// Used by imusd_front, imusd_back and imu_serial_frame_deframer; no dependencies.
package imusd_pkg;

    localparam int FRAME_BYTES = 11;
    localparam logic [3:0] FRAME_COUNT = 4'd11;
    localparam logic [7:0] SYNC_RESET = 8'h55;
    localparam logic [7:0] TYPE_ACC = 8'h51;
    localparam logic [7:0] TYPE_RATE = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_CNT = 3'd4;

    localparam int TDATA_W = 56;

    typedef struct packed {
        logic signed [15:0] third_value;
        logic signed [15:0] second_value;
        logic signed [15:0] first_value;
        logic [1:0]         frame_kind;
    } frame_t;

    typedef struct packed {
        logic   push;
        frame_t frame;
    } push_t;

endpackage

// File: hdl/imusd_front.sv
// Front end: byte window, frame count and frame detection (sync and checksum).
// Depends on imusd_pkg; feeds decoded frames into imusd_back.
module imusd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        sync_byte,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        rx_byte,
    input  logic              queue_full,
    output imusd_pkg::push_t  push_out
);

    logic [7:0] win_reg [imusd_pkg::FRAME_BYTES];
    logic [3:0] cnt_reg, cnt_next, cnt_base;
    logic       fresh_reg, fresh_next;

    logic [7:0] sum_a, sum_b, sum_c, sum_d, sum_e, sum_f, sum;
    logic       match, type_ok, want_push, blocked, consume, accept;

    // Checksum over bytes 0..9 as a small adder tree.
    always_comb begin
        sum_a = win_reg[0] + win_reg[1];
        sum_b = win_reg[2] + win_reg[3];
        sum_c = win_reg[4] + win_reg[5];
        sum_d = win_reg[6] + win_reg[7];
        sum_e = win_reg[8] + win_reg[9];
        sum_f = (sum_a + sum_b) + (sum_c + sum_d);
        sum   = sum_f + sum_e;
    end

    // A window is checked in the cycle after its last byte, or while blocked.
    assign match = fresh_reg && (cnt_reg == imusd_pkg::FRAME_COUNT)
                   && (win_reg[0] == sync_byte) && (sum == win_reg[10]);
    assign type_ok = (win_reg[1] == imusd_pkg::TYPE_ACC)
                     || (win_reg[1] == imusd_pkg::TYPE_RATE)
                     || (win_reg[1] == imusd_pkg::TYPE_ANGLE);
    assign want_push = match && type_ok;
    assign blocked   = want_push && queue_full;
    assign consume   = match && !blocked;
    assign s_tready  = !blocked;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        cnt_base = consume ? 4'd0 : cnt_reg;
        if (accept && (cnt_base != imusd_pkg::FRAME_COUNT)) begin
            cnt_next = cnt_base + 4'd1;
        end else begin
            cnt_next = cnt_base;
        end
        fresh_next = accept || blocked;
    end

    always_comb begin
        push_out.push                     = want_push && !queue_full;
        push_out.frame.frame_kind         = win_reg[1][1:0] - 2'd1;
        push_out.frame.first_value        = {win_reg[3], win_reg[2]};
        push_out.frame.second_value       = {win_reg[5], win_reg[4]};
        push_out.frame.third_value        = {win_reg[7], win_reg[6]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 4'd0;
            fresh_reg <= 1'b0;
            for (int i = 0; i < imusd_pkg::FRAME_BYTES; i++) begin
                win_reg[i] <= 8'd0;
            end
        end else begin
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            if (accept) begin
                for (int i = 0; i < imusd_pkg::FRAME_BYTES - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[imusd_pkg::FRAME_BYTES-1] <= rx_byte;
            end
        end
    end

endmodule

// File: hdl/imusd_back.sv
// Back end: short frame queue and result channel driver.
// Depends on imusd_pkg; takes decoded frames from imusd_front.
module imusd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  imusd_pkg::push_t                  push_in,
    output logic                              queue_full,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [imusd_pkg::TDATA_W-1:0]     m_tdata
);

    imusd_pkg::frame_t mem [imusd_pkg::QUEUE_DEPTH];
    logic [imusd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [imusd_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic pop;
    imusd_pkg::frame_t head;

    assign queue_full = (cnt_reg == imusd_pkg::QUEUE_FULL_CNT);
    assign m_tvalid   = (cnt_reg != '0);
    assign pop        = m_tvalid && m_tready;
    assign head       = mem[rd_ptr_reg];
    assign m_tdata    = {6'd0, head.third_value, head.second_value,
                         head.first_value, head.frame_kind};

    always_comb begin
        cnt_next = cnt_reg;
        if (push_in.push && !pop) begin
            cnt_next = cnt_reg + 3'd1;
        end else if (pop && !push_in.push) begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem[wr_ptr_reg] <= push_in.frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push_in.push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

endmodule

// File: hdl/imu_serial_frame_deframer.sv
// Top level of the IMU serial frame deframer.
// Depends on imusd_pkg, imusd_front and imusd_back.
//
// Usage: serial bytes enter one word at a time on the s_ channel (tdata bits
// 7:0 carry the byte). The block keeps an 11-byte sliding window and detects
// frames that start with the sync byte and whose byte 10 equals the 8-bit sum
// of bytes 0..9; frames never overlap the previously detected frame.
// Frames of type 0x51, 0x52 and 0x53 produce one word on the m_ channel
// holding the kind and three signed little-endian 16-bit values; other
// detected frames are dropped silently.
// Throughput: one byte per cycle while s_tready is high. The front end checks
// completed window in the cycle after the byte that completed it; frames of a
// kept type go into the queue for m_. A four-entry queue sits between detection
// and the result channel. When the receiver stalls, the queue absorbs frames;
// only when it is full and a frame of a kept type is detected does s_tready
// drop until a queue slot frees up. The sync byte is written over the cfg_
// channel (always ready); the user must write it only while idle, which the
// block does not enforce. Reset (aresetn low, synchronous) clears the window
// to zeros, the frame count, the queue, and restores the sync byte to 0x55.
module imu_serial_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: cfg_data[7:0] = sync_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // Input word, tdata[7:0] = rx_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Result word, tdata[1:0] = frame_kind, [17:2] = first_value,
    // [33:18] = second_value, [49:34] = third_value, [55:50] = zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata
);

    logic [7:0] sync_reg;
    logic queue_full;
    imusd_pkg::push_t push;

    assign cfg_ready = 1'b1;

    // The sync byte register is the only configuration state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= imusd_pkg::SYNC_RESET;
        end else if (cfg_valid) begin
            sync_reg <= cfg_data;
        end
    end

    imusd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sync_byte  (sync_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .rx_byte    (s_tdata),
        .queue_full (queue_full),
        .push_out   (push)
    );

    imusd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_in    (push),
        .queue_full (queue_full),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
